// File: hw/rtl/flwf_pkg.sv
// Package with types, constants and the byte classifier of the fixed-length word filter.
`timescale 1ns / 1ps

package flwf_pkg;

    localparam int MAX_WORD = 32;
    localparam int ADDR_W = $clog2(MAX_WORD);
    localparam int COUNT_W = $clog2(MAX_WORD + 2);
    localparam int LEN_W = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_ch;
        logic       line_end;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    function automatic logic is_excluded(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            8'h00, 8'hB9, 8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29, 8'h2A,
            8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, [8'h30:8'h39], 8'h3A, 8'h3B, 8'h3D,
            8'h3F, 8'h40, 8'h5B, 8'h5D, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7C, 8'h7D,
            8'h7E: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// File: hw/rtl/fixed_length_word_filter.sv
// Top level of the fixed-length word filter: control sequencer and output register.
// An ordinary byte gives no result, and the next byte can be taken in the next cycle.
// A space or end of line that ends a kept word stalls the input while a leading space (for a
// later word on the line), the word's bytes and, at end of line, the line-end item are emitted.
// The first result of a transaction passes the sequencer state and then the output register.
// Reset clears the word length count, the emitted flag and the sequencer; word_len resets to 1.
`timescale 1ns / 1ps

module fixed_length_word_filter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  flwf_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output flwf_pkg::out_item_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [flwf_pkg::LEN_W-1:0]   cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SPACE = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_EOL = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [flwf_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                           clean_reg, clean_next;
    logic                           any_reg, any_next;
    logic                           eol_pend_reg, eol_pend_next;
    logic [flwf_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    logic [flwf_pkg::LEN_W-1:0]     word_len_reg;
    logic                           out_valid_reg, out_valid_next;
    flwf_pkg::out_item_t            out_data_reg, out_data_next;

    flwf_pkg::store_req_t           req;
    logic [7:0]                     rdata;
    logic                           in_fire;
    logic                           out_free;
    logic                           qualify;
    logic                           last_byte;

    flwf_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign qualify = (count_reg != '0) && clean_reg
        && (count_reg <= flwf_pkg::COUNT_W'(flwf_pkg::MAX_WORD))
        && (flwf_pkg::LEN_W'(count_reg) == word_len_reg);
    assign last_byte = (flwf_pkg::LEN_W'(idx_reg) == (word_len_reg - flwf_pkg::LEN_W'(1)));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        clean_next = clean_reg;
        any_next = any_reg;
        eol_pend_next = eol_pend_reg;
        idx_next = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next = out_data_reg;
        req = '0;
        req.wr_addr = count_reg[flwf_pkg::ADDR_W-1:0];
        req.wr_data = in_data.ch;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.end_of_line || (in_data.ch == flwf_pkg::CH_SPACE))
                    begin
                        count_next = '0;
                        clean_next = 1'b1;
                        eol_pend_next = in_data.end_of_line;
                        any_next = in_data.end_of_line ? 1'b0 : (any_reg || qualify);
                        if (qualify)
                        begin
                            req.rd_en = 1'b1;
                            req.rd_addr = '0;
                            idx_next = '0;
                            state_next = any_reg ? ST_SPACE : ST_DATA;
                        end
                        else if (in_data.end_of_line)
                        begin
                            state_next = ST_EOL;
                        end
                    end
                    else if ((in_data.ch == flwf_pkg::CH_TAB)
                             || (in_data.ch == flwf_pkg::CH_APOS))
                    begin
                        count_next = '0;
                        clean_next = 1'b1;
                    end
                    else
                    begin
                        req.wr_en = (count_reg < flwf_pkg::COUNT_W'(flwf_pkg::MAX_WORD));
                        if (count_reg <= flwf_pkg::COUNT_W'(flwf_pkg::MAX_WORD))
                        begin
                            count_next = count_reg + flwf_pkg::COUNT_W'(1);
                        end
                        if (flwf_pkg::is_excluded(in_data.ch))
                        begin
                            clean_next = 1'b0;
                        end
                    end
                end
            end
            ST_SPACE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = '{out_ch: flwf_pkg::CH_SPACE, line_end: 1'b0, last: 1'b0};
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = '{out_ch: rdata, line_end: 1'b0,
                                      last: last_byte && !eol_pend_reg};
                    if (last_byte)
                    begin
                        state_next = eol_pend_reg ? ST_EOL : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + flwf_pkg::ADDR_W'(1);
                        req.rd_en = 1'b1;
                        req.rd_addr = idx_reg + flwf_pkg::ADDR_W'(1);
                    end
                end
            end
            ST_EOL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = '{out_ch: flwf_pkg::CH_NUL, line_end: 1'b1, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            clean_reg <= 1'b1;
            any_reg <= 1'b0;
            eol_pend_reg <= 1'b0;
            idx_reg <= '0;
            word_len_reg <= flwf_pkg::LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clean_reg <= clean_next;
            any_reg <= any_next;
            eol_pend_reg <= eol_pend_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                word_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= flwf_pkg::COUNT_W'(flwf_pkg::MAX_WORD + 1))
        else $error("word length count beyond saturation");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (flwf_pkg::LEN_W'(idx_reg) < word_len_reg))
        else $error("store read index beyond the kept word length");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.wr_en)
        else $error("word store written while a word is replayed");

    a_line_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.line_end)
            |-> (out_data_reg.last && (out_data_reg.out_ch == flwf_pkg::CH_NUL)))
        else $error("malformed line-end item");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.end_of_line) |=> (!any_reg && (count_reg == '0)))
        else $error("end of line left word state behind");

endmodule

// File: hw/rtl/flwf_store.sv
// Word store: synchronous memory holding the bytes of the current word.
`timescale 1ns / 1ps

module flwf_store (
    input  logic                clk,
    input  flwf_pkg::store_req_t req,
    output logic [7:0]          rdata
);

    logic [7:0] store_mem [flwf_pkg::MAX_WORD];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= store_mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
